// ===== design/delimiter_string_splitter_macros.svh =====
// Assertion macros shared by the delimiter string splitter.
// Included by the top level; depends on nothing else.
`ifndef DELIMITER_STRING_SPLITTER_MACROS_SVH
`define DELIMITER_STRING_SPLITTER_MACROS_SVH

`define DSS_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("dss: same-cycle implication violated");

`define DSS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("dss: next-cycle implication violated");

`endif

// ===== design/dss_pkg.sv =====
// Package of the delimiter string splitter: beat types, cell control and constants.
// Used by every module of the block; depends on nothing.
package dss_pkg;

    localparam int DEF_MAX_DELIM = 8;
    localparam int BYTE_W        = 8;
    localparam int DELIM_W       = 64;
    localparam int LEN_REG_W     = 4;
    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 64;

    localparam logic REG_DELIM_BYTES  = 1'b0;
    localparam logic REG_DELIM_LENGTH = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_text;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] token_byte;
        logic              byte_valid;
        logic              token_end;
        logic              run_last;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

// ===== design/dss_cell.sv =====
// One byte cell of the delimiter window chain.
// Depends on dss_pkg; instantiated by delimiter_string_splitter.
module dss_cell (
    input  logic                        i_clk,
    input  dss_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_take_new,
    input  logic [dss_pkg::BYTE_W-1:0]  i_new_byte,
    input  logic [dss_pkg::BYTE_W-1:0]  i_delim_byte,
    input  logic [dss_pkg::BYTE_W-1:0]  i_next_eff,
    output logic [dss_pkg::BYTE_W-1:0]  o_eff,
    output logic                        o_eq
);

    logic [dss_pkg::BYTE_W-1:0] r_byte;
    logic [dss_pkg::BYTE_W-1:0] n_byte;

    assign o_eff  = i_take_new ? i_new_byte : r_byte;
    assign o_eq   = (o_eff == i_delim_byte);
    assign n_byte = i_ctl.shift ? i_next_eff : o_eff;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_byte <= n_byte;
        end
    end

endmodule

// ===== design/dss_cfg.sv =====
// APB-style configuration registers of the splitter and the clamped delimiter length.
// Depends on dss_pkg; instantiated by delimiter_string_splitter.
module dss_cfg #(
    parameter int MAX_DELIM = dss_pkg::DEF_MAX_DELIM,
    localparam int FW = $clog2(MAX_DELIM + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dss_pkg::PADDR_W-1:0]  paddr,
    input  logic [dss_pkg::PDATA_W-1:0]  pwdata,
    output logic [dss_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [dss_pkg::DELIM_W-1:0]  o_delim,
    output logic [FW-1:0]                o_len
);

    logic [dss_pkg::DELIM_W-1:0]   r_delim;
    logic [dss_pkg::LEN_REG_W-1:0] r_len;
    logic                          wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_delim = r_delim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= '0;
            r_len   <= dss_pkg::LEN_REG_W'(1);
        end else if (wr_en) begin
            case (paddr[3])
                dss_pkg::REG_DELIM_BYTES:  r_delim <= pwdata[dss_pkg::DELIM_W-1:0];
                dss_pkg::REG_DELIM_LENGTH: r_len   <= pwdata[dss_pkg::LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            dss_pkg::REG_DELIM_BYTES:  prdata = dss_pkg::PDATA_W'(r_delim);
            dss_pkg::REG_DELIM_LENGTH: prdata = dss_pkg::PDATA_W'(r_len);
            default:                   prdata = '0;
        endcase
    end

    always_comb begin
        if (r_len == '0) begin
            o_len = FW'(1);
        end else if (r_len > dss_pkg::LEN_REG_W'(MAX_DELIM)) begin
            o_len = FW'(MAX_DELIM);
        end else begin
            o_len = FW'(r_len);
        end
    end

endmodule

// ===== design/delimiter_string_splitter.sv =====
// Delimiter string splitter: cuts a byte stream into tokens at a multi-byte delimiter.
// Depends on dss_pkg, dss_cfg, dss_cell and delimiter_string_splitter_macros.svh.
// The window of recent bytes lives in a row of MAX_DELIM byte cells that compare
// against the delimiter in parallel and shift toward the oldest cell as bytes leave.
// Each beat on the output carries one result, so an input beat that yields several
// results stalls the input while they leave one at a time through the single output
// register. The window needs no clearing after reset.
`include "delimiter_string_splitter_macros.svh"

module delimiter_string_splitter #(
    parameter int MAX_DELIM = dss_pkg::DEF_MAX_DELIM
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  dss_pkg::t_in_beat            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output dss_pkg::t_out_beat           o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dss_pkg::PADDR_W-1:0]  paddr,
    input  logic [dss_pkg::PDATA_W-1:0]  pwdata,
    output logic [dss_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int FW = $clog2(MAX_DELIM + 1);

    typedef enum logic {
        PH_MAIN,
        PH_FLUSH
    } t_phase;

    logic [dss_pkg::DELIM_W-1:0] delim;
    logic [FW-1:0]               len;

    logic [dss_pkg::BYTE_W-1:0]  eff [MAX_DELIM];
    logic [MAX_DELIM-1:0]        eq;
    logic [MAX_DELIM-1:0]        sel_new;
    dss_pkg::t_cell_ctl          cell_ctl;

    t_phase             r_phase, n_phase, cur_phase;
    logic               r_busy;
    logic [FW-1:0]      r_fill, n_fill, cur_fill;
    logic               r_tok, n_tok;
    logic               r_eot, cur_eot;
    logic               r_out_v;
    dss_pkg::t_out_beat r_out;

    logic match, emit, emit_close, shift, more, go_flush, adv, step;

    dss_cfg #(
        .MAX_DELIM(MAX_DELIM)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_delim (delim),
        .o_len   (len)
    );

    assign cell_ctl.load  = step;
    assign cell_ctl.shift = shift;

    for (genvar k = 0; k < MAX_DELIM; k++) begin : g_cell
        logic [dss_pkg::BYTE_W-1:0] next_eff;

        if (k == MAX_DELIM - 1) begin : g_tail
            assign next_eff = '0;
        end else begin : g_link
            assign next_eff = eff[k+1];
        end

        assign sel_new[k] = !r_busy && (r_fill == FW'(k));

        dss_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_take_new   (sel_new[k]),
            .i_new_byte   (i_in_data.in_byte),
            .i_delim_byte (delim[k*dss_pkg::BYTE_W +: dss_pkg::BYTE_W]),
            .i_next_eff   (next_eff),
            .o_eff        (eff[k]),
            .o_eq         (eq[k])
        );
    end

    always_comb begin
        match = 1'b1;
        for (int k = 0; k < MAX_DELIM; k++) begin
            if ((FW'(k) < len) && !eq[k]) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        cur_fill  = r_busy ? r_fill : FW'(r_fill + 1'b1);
        cur_phase = r_busy ? r_phase : PH_MAIN;
        cur_eot   = r_busy ? r_eot : i_in_data.end_of_text;

        emit       = 1'b0;
        emit_close = 1'b0;
        shift      = 1'b0;
        go_flush   = 1'b0;
        more       = 1'b0;
        n_fill     = cur_fill;
        n_tok      = r_tok;
        n_phase    = cur_phase;

        if (cur_phase == PH_MAIN) begin
            if (cur_fill > len) begin
                emit   = 1'b1;
                shift  = 1'b1;
                n_fill = cur_fill - 1'b1;
                n_tok  = 1'b1;
            end else if (cur_fill == len) begin
                if (match) begin
                    n_fill = '0;
                    if (r_tok) begin
                        emit       = 1'b1;
                        emit_close = 1'b1;
                        n_tok      = 1'b0;
                        n_phase    = PH_FLUSH;
                    end
                end else begin
                    emit    = 1'b1;
                    shift   = 1'b1;
                    n_fill  = cur_fill - 1'b1;
                    n_tok   = 1'b1;
                    n_phase = PH_FLUSH;
                end
            end else begin
                go_flush = 1'b1;
            end
        end else begin
            go_flush = 1'b1;
        end

        if (go_flush && cur_eot) begin
            if (cur_fill != '0) begin
                emit    = 1'b1;
                shift   = 1'b1;
                n_fill  = cur_fill - 1'b1;
                n_tok   = 1'b1;
                n_phase = PH_FLUSH;
            end else if (r_tok) begin
                emit       = 1'b1;
                emit_close = 1'b1;
                n_tok      = 1'b0;
                n_phase    = PH_FLUSH;
            end
        end

        if (emit) begin
            if (n_phase == PH_MAIN) begin
                more = (n_fill >= len) || cur_eot;
            end else begin
                more = cur_eot && ((n_fill != '0) || n_tok);
            end
        end
    end

    assign adv        = !emit || !r_out_v || !i_out_stall;
    assign o_in_stall = r_busy || !adv;
    assign step       = r_busy ? adv : (i_in_valid && !o_in_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAIN;
            r_busy  <= 1'b0;
            r_fill  <= '0;
            r_tok   <= 1'b0;
            r_eot   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (step) begin
                r_phase <= n_phase;
                r_busy  <= emit && more;
                r_fill  <= n_fill;
                r_tok   <= n_tok;
                r_eot   <= cur_eot;
            end
            if (step && emit) begin
                r_out_v            <= 1'b1;
                r_out.token_byte   <= emit_close ? '0 : eff[0];
                r_out.byte_valid   <= !emit_close;
                r_out.token_end    <= emit_close;
                r_out.run_last     <= !more;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    `DSS_ASSERT_IMPLY(a_room_for_byte, i_clk, i_rst_n, !r_busy, r_fill < FW'(MAX_DELIM))
    `DSS_ASSERT_IMPLY(a_more_means_busy, i_clk, i_rst_n, r_out_v && !r_out.run_last, r_busy)
    `DSS_ASSERT_IMPLY(a_text_end_clears, i_clk, i_rst_n, !r_busy && r_eot, (r_fill == '0) && !r_tok)
    `DSS_ASSERT_NEXT(a_busy_step_loads, i_clk, i_rst_n, r_busy && adv, r_out_v)

endmodule
